[hdl/edge_aware_box_blur_3x3_top_assert.svh]
// Assertion macros for the edge-aware box blur checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef EDGE_AWARE_BOX_BLUR_3X3_TOP_ASSERT_SVH
`define EDGE_AWARE_BOX_BLUR_3X3_TOP_ASSERT_SVH

// Same-cycle implication.
`define EABB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eabb assertion failed");

// Next-cycle implication.
`define EABB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eabb assertion failed");

`endif

[hdl/eabb_pkg.sv]
// ----------------------------------------------------------------------------
// eabb_pkg
// Shared constants, types and control structs of the edge-aware box blur.
// ----------------------------------------------------------------------------
package eabb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int WIDTH_W  = 11;                 // image_width register
    localparam int HEIGHT_W = 13;                 // image_height register
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int OROW_W   = 13;
    localparam int IROW_W   = 14;                 // runs a few rows past the frame on flush
    localparam int PIX_W    = 24;
    localparam int SUM_W    = 12;
    localparam int NUM_W    = 13;
    localparam int CNT_W    = 4;
    localparam int DEN_W    = 5;
    localparam int QUO_W    = 8;
    localparam int STEP_W   = 3;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SUM,
        S_DIV,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic exec;
        logic sum;
        logic div;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic out_done;
        logic emit;
        logic is_flush;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/eabb_in_if.sv]
// ----------------------------------------------------------------------------
// eabb_in_if
// Input item channel: command and pixel with valid/ready.
// ----------------------------------------------------------------------------
interface eabb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [23:0] pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

[hdl/eabb_out_if.sv]
// ----------------------------------------------------------------------------
// eabb_out_if
// Result item channel: blurred pixel and end-of-frame flag.
// ----------------------------------------------------------------------------
interface eabb_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] blurred_pixel;
    logic        last_of_frame;

    modport source (output valid, output blurred_pixel, output last_of_frame, input ready);
    modport sink   (input valid, input blurred_pixel, input last_of_frame, output ready);
endinterface

[hdl/eabb_cfg_if.sv]
// ----------------------------------------------------------------------------
// eabb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface eabb_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [12:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/eabb_dp.sv]
// ----------------------------------------------------------------------------
// eabb_dp
// Datapath: config registers, line store, 3x3 window, position counters,
// window sum, per-channel serial divider and output register.
// ----------------------------------------------------------------------------
module eabb_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  eabb_pkg::ctrl_cmd_t      ctrl,
    output eabb_pkg::dp_status_t     status,
    input  logic                     in_cmd,
    input  logic [23:0]              in_pixel,
    input  logic                     cfg_write,
    input  logic                     cfg_index,
    input  logic [12:0]              cfg_data,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [23:0]              out_pixel,
    output logic                     out_last
);
    import eabb_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    logic                cmd_reg;
    logic [PIX_W-1:0]    pix_reg;

    logic [COL_W-1:0]    in_col_reg,  in_col_next;
    logic [IROW_W-1:0]   in_row_reg,  in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [OROW_W-1:0]   out_row_reg, out_row_next;

    logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]  rd_data_reg;
    logic [PIX_W-1:0]    win_reg [9];

    logic [COL_W-1:0]    col_c;
    logic                emit;
    logic                restart;
    logic [PIX_W-1:0]    top_px, mid_px;

    logic                row_top_reg, row_bot_reg, col_l_reg, col_r_reg, last_reg;
    logic [1:0]          rows, cols;
    logic [CNT_W-1:0]    count;

    logic [SUM_W-1:0]    sum [3];
    logic [NUM_W-1:0]    num [3];
    logic [DEN_W-1:0]    rem_reg [3];
    logic [QUO_W-1:0]    numlo_reg [3];
    logic [QUO_W-1:0]    quo_reg [3];
    logic [DEN_W-1:0]    den_reg;
    logic [STEP_W-1:0]   step_reg;

    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_pix_reg;
    logic                out_last_reg;

    // clamp registers to their legal ranges
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            eff_w = WIDTH_W'(MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg == '0)
            eff_h = HEIGHT_W'(1);
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        else
            eff_h = height_reg;
    end

    assign col_c  = ({1'b0, in_col_reg} >= eff_w) ? '0 : in_col_reg;
    assign top_px = rd_data_reg[2*PIX_W-1:PIX_W];
    assign mid_px = rd_data_reg[PIX_W-1:0];

    assign emit = ((in_row_reg >= IROW_W'(2)) || (in_row_reg == IROW_W'(1) && col_c != '0))
                  && (out_row_reg < eff_h);

    assign restart = cfg_write
                     || (ctrl.accept && in_cmd == CMD_PIXEL
                         && in_row_reg >= {1'b0, eff_h});

    assign status.frame_done = (in_row_reg >= {1'b0, eff_h});
    assign status.out_done   = (out_row_reg >= eff_h);
    assign status.emit       = emit;
    assign status.is_flush   = (cmd_reg == CMD_FLUSH);
    assign status.div_last   = (step_reg == '1);
    assign status.out_free   = !out_valid_reg || out_ready;

    // position counters
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (ctrl.exec)
        begin
            if (({1'b0, col_c} + WIDTH_W'(1)) >= eff_w)
            begin
                in_col_next = '0;
                if (in_row_reg != '1)
                    in_row_next = in_row_reg + IROW_W'(1);
            end
            else
                in_col_next = col_c + COL_W'(1);
            if (emit)
            begin
                if (({1'b0, out_col_reg} + WIDTH_W'(1)) >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                    out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_W'(1024);
            height_reg  <= HEIGHT_W'(768);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (ctrl.exec)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= top_px;
                win_reg[5] <= mid_px;
                win_reg[8] <= (cmd_reg == CMD_PIXEL) ? pix_reg : '0;
            end
            if (ctrl.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // line store: older row in the upper half, newer row in the lower half
    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
            rd_data_reg <= line_mem[col_c];
        if (ctrl.exec && cmd_reg == CMD_PIXEL)
            line_mem[col_c] <= {mid_px, pix_reg};
    end

    assign rows  = 2'd1 + {1'b0, row_top_reg} + {1'b0, row_bot_reg};
    assign cols  = 2'd1 + {1'b0, col_l_reg} + {1'b0, col_r_reg};
    assign count = {2'b00, rows} * {2'b00, cols};

    // masked window sum per channel
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                if ((k / 3 != 0 || row_top_reg) && (k / 3 != 2 || row_bot_reg)
                    && (k % 3 != 0 || col_l_reg) && (k % 3 != 2 || col_r_reg))
                    sum[ch] = sum[ch] + SUM_W'(win_reg[k][(2-ch)*8 +: 8]);
            end
            num[ch] = {sum[ch], 1'b0} + NUM_W'(count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg <= in_cmd;
            pix_reg <= in_pixel;
        end
        if (ctrl.exec && emit)
        begin
            row_top_reg <= (out_row_reg != '0);
            row_bot_reg <= ({1'b0, out_row_reg} + IROW_W'(1)) < {1'b0, eff_h};
            col_l_reg   <= (out_col_reg != '0);
            col_r_reg   <= ({1'b0, out_col_reg} + WIDTH_W'(1)) < eff_w;
            last_reg    <= (out_row_reg == eff_h - HEIGHT_W'(1))
                           && ({1'b0, out_col_reg} == eff_w - WIDTH_W'(1));
        end
        if (ctrl.sum)
        begin
            // quotient fits 8 bits, so the top bits start below the divisor
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_reg[ch]   <= num[ch][NUM_W-1:QUO_W];
                numlo_reg[ch] <= num[ch][QUO_W-1:0];
            end
            den_reg  <= {count, 1'b0};
            step_reg <= '0;
        end
        else if (ctrl.div)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                if ({rem_reg[ch], numlo_reg[ch][QUO_W-1]} >= {1'b0, den_reg})
                begin
                    rem_reg[ch] <= DEN_W'({rem_reg[ch], numlo_reg[ch][QUO_W-1]}
                                          - {1'b0, den_reg});
                    quo_reg[ch] <= {quo_reg[ch][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[ch] <= {rem_reg[ch][DEN_W-2:0], numlo_reg[ch][QUO_W-1]};
                    quo_reg[ch] <= {quo_reg[ch][QUO_W-2:0], 1'b0};
                end
                numlo_reg[ch] <= {numlo_reg[ch][QUO_W-2:0], 1'b0};
            end
            step_reg <= step_reg + STEP_W'(1);
        end
        if (ctrl.load)
        begin
            out_pix_reg  <= {quo_reg[0], quo_reg[1], quo_reg[2]};
            out_last_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pix_reg;
    assign out_last  = out_last_reg;

endmodule

[hdl/eabb_ctrl.sv]
// ----------------------------------------------------------------------------
// eabb_ctrl
// Controller: sequences line store read, window update, sum, divide, output.
// ----------------------------------------------------------------------------
module eabb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_cmd,
    input  eabb_pkg::dp_status_t  status,
    output eabb_pkg::ctrl_cmd_t   ctrl,
    output logic                  in_ready,
    output logic                  cfg_ready
);
    import eabb_pkg::*;

    state_t state_reg, state_next;
    logic   again_reg, again_next;

    always_comb
    begin
        state_next = state_reg;
        again_next = again_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    again_next = 1'b0;
                    if (in_cmd == CMD_PIXEL)
                        state_next = S_READ;
                    else if (status.frame_done && !status.out_done)
                        state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_EXEC;
            S_EXEC:
            begin
                // a flush tick may need a second column before a result shows
                if (status.emit)
                    state_next = S_SUM;
                else if (status.is_flush && !again_reg && !status.out_done)
                begin
                    again_next = 1'b1;
                    state_next = S_READ;
                end
                else
                    state_next = S_IDLE;
            end
            S_SUM:
                state_next = S_DIV;
            S_DIV:
                if (status.div_last)
                    state_next = S_LOAD;
            S_LOAD:
                if (status.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cfg_ready   = 1'b1;
                ctrl.accept = in_valid;
            end
            S_READ: ctrl.rd   = 1'b1;
            S_EXEC: ctrl.exec = 1'b1;
            S_SUM:  ctrl.sum  = 1'b1;
            S_DIV:  ctrl.div  = 1'b1;
            S_LOAD: ctrl.load = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            again_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            again_reg <= again_next;
        end
    end

endmodule

[hdl/edge_aware_box_blur_3x3_top.sv]
// A result follows the accept of the item that yields it through read, window update,
// sum, 8 divider steps and output load; a two-column flush adds a second read and update.
// Items are taken only in idle, so a new item waits until the last one, with any output
// stall, is done; an ignored flush stays in idle, and an item with no result skips the divider.
// Reset (rst_n, async low) clears counters and window; line store is not cleared.
// ----------------------------------------------------------------------------
// edge_aware_box_blur_3x3_top
// Streaming 3x3 box blur with edge-aware averaging over RGB pixels.
// ----------------------------------------------------------------------------
module edge_aware_box_blur_3x3_top (
    input  logic       clk,
    input  logic       rst_n,
    eabb_in_if.sink    in_ch,
    eabb_out_if.source out_ch,
    eabb_cfg_if.sink   cfg
);
    import eabb_pkg::*;

    ctrl_cmd_t  ctrl;
    dp_status_t status;
    logic       in_ready;
    logic       cfg_ready;

    assign in_ch.ready = in_ready;
    assign cfg.ready   = cfg_ready;

    eabb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .status    (status),
        .ctrl      (ctrl),
        .in_ready  (in_ready),
        .cfg_ready (cfg_ready)
    );

    eabb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .in_cmd    (in_ch.cmd),
        .in_pixel  (in_ch.pixel),
        .cfg_write (cfg.valid && cfg_ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_pixel (out_ch.blurred_pixel),
        .out_last  (out_ch.last_of_frame)
    );

endmodule

[hdl/eabb_checker.sv]
// ----------------------------------------------------------------------------
// eabb_checker
// Port-level checks of the blur block, bound to the top level.
// ----------------------------------------------------------------------------
`include "edge_aware_box_blur_3x3_top_assert.svh"

module eabb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_cmd,
    input logic        cfg_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] out_pixel
);
    // pixel items always start a multi-cycle job
    `EABB_ASSERT_NEXT(a_pixel_busy, in_valid && in_ready && !in_cmd, !in_ready)
    // config is only taken while the item channel is ready
    `EABB_ASSERT_NOW(a_cfg_with_in, cfg_ready, in_ready)
    `EABB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `EABB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_pixel))
endmodule

bind edge_aware_box_blur_3x3_top eabb_checker u_eabb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .cfg_ready (cfg.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pixel (out_ch.blurred_pixel)
);
